// ===== hdl/rcq_pkg.sv =====
// shared types, sizes and helpers for the rotating circular queue
package rcq_pkg;

   localparam int DEPTH       = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int AMT_W       = 8;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_ROTATE = 2'd2,
      OP_NOP    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ERR_OK    = 2'd0,
      ERR_FULL  = 2'd1,
      ERR_EMPTY = 2'd2,
      ERR_ZERO  = 2'd3
   } err_type;

   typedef logic [IDX_W-1:0]       idx_type;
   typedef logic [CNT_W-1:0]       cnt_type;
   typedef logic [VALUE_WIDTH-1:0] value_type;

   // base plus offset around the ring, offset never above DEPTH
   function automatic idx_type ring_add(input idx_type base, input cnt_type ofs);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(ofs);
      if (sum >= (CNT_W + 1)'(DEPTH)) begin
         sum = sum - (CNT_W + 1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

// ===== hdl/rcq_chan_if.sv =====
// request and response channel interfaces of the rotating circular queue
interface rcq_req_if;
   logic                                      valid;
   logic                                      ready;
   rcq_pkg::func_type                         func;
   logic signed [rcq_pkg::VALUE_WIDTH-1:0]    push_value;
   logic        [rcq_pkg::AMT_W-1:0]          rotate_amount;

   modport source (output valid, func, push_value, rotate_amount, input ready);
   modport sink   (input valid, func, push_value, rotate_amount, output ready);
endinterface

interface rcq_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [rcq_pkg::VALUE_WIDTH-1:0]    current_value;
   logic        [rcq_pkg::CNT_W-1:0]          queue_size;
   logic                                      is_empty;
   rcq_pkg::err_type                          error_code;

   modport source (output valid, current_value, queue_size, is_empty, error_code,
                   input ready);
   modport sink   (input valid, current_value, queue_size, is_empty, error_code,
                   output ready);
endinterface

// ===== hdl/rotating_circular_queue_unit.sv =====
// top level of the rotating circular queue: ring store, control and response register
//
//   channel   dir   payload                                    word accepted when
//   req_chan  in    func, push_value, rotate_amount            valid && ready
//   rsp_chan  out   current_value, queue_size, is_empty,       valid && ready
//                   error_code
//
// push, pop, no-op and every flagged request load their response in the accept
// cycle; a rotate by k on a non-empty queue is paced by the single read port of
// the ring store: the accept cycle reads the front, then each cycle moves one
// word behind the tail and, for all but the k-th word, reads the next front
// one request is in flight at a time; a new word is taken while the previous
// response still sits in the output register as long as that register frees up
// synchronous active-high reset empties the queue; the store itself is not cleared
module rotating_circular_queue_unit (
   input logic       clock,
   input logic       reset,
   rcq_req_if.sink   req_chan,
   rcq_rsp_if.source rsp_chan
);
   import rcq_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_ROT
   } state_type;

   // control state
   state_type          state_ff, state_in;
   idx_type            head_ff, head_in;
   cnt_type            count_ff, count_in;
   logic [AMT_W-1:0]   steps_ff, steps_in;
   value_type          tail_ff, tail_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   value_type          rsp_value_ff, rsp_value_in;
   cnt_type            rsp_size_ff, rsp_size_in;
   err_type            rsp_err_ff, rsp_err_in;
   logic               rsp_load;

   // ring store, one write and one read port, registered read data
   value_type          item_store_ff [DEPTH];
   value_type          mem_rd_ff;
   logic               fwd_ff;
   value_type          fwd_data_ff;
   logic               mem_we, mem_re;
   idx_type            mem_waddr, mem_raddr;
   value_type          mem_wdata;

   logic               accept;
   idx_type            wr_pos, next_head;
   value_type          rd_data;

   assign accept    = req_chan.valid && req_chan.ready;
   assign wr_pos    = ring_add(head_ff, count_ff);
   assign next_head = ring_add(head_ff, CNT_W'(1));
   // a read that hit the entry written in the same cycle takes the written word
   assign rd_data   = fwd_ff ? fwd_data_ff : mem_rd_ff;

   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      steps_in     = steps_ff;
      tail_in      = tail_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = wr_pos;
      mem_raddr    = head_ff;
      mem_wdata    = rd_data;
      rsp_load     = 1'b0;
      rsp_value_in = (count_ff == '0) ? '0 : tail_ff;
      rsp_size_in  = count_ff;
      rsp_err_in   = ERR_OK;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_chan.func)
                  OP_PUSH: begin
                     rsp_load = 1'b1;
                     if (count_ff == CNT_W'(DEPTH)) begin
                        rsp_err_in = ERR_FULL;
                     end else begin
                        mem_we       = 1'b1;
                        mem_wdata    = req_chan.push_value;
                        tail_in      = req_chan.push_value;
                        count_in     = count_ff + CNT_W'(1);
                        rsp_value_in = req_chan.push_value;
                        rsp_size_in  = count_ff + CNT_W'(1);
                     end
                  end
                  OP_POP: begin
                     rsp_load = 1'b1;
                     if (count_ff == '0) begin
                        rsp_err_in = ERR_EMPTY;
                     end else begin
                        count_in    = count_ff - CNT_W'(1);
                        rsp_size_in = count_ff - CNT_W'(1);
                        // popping the last word leaves the ring empty at slot zero
                        if (count_ff == CNT_W'(1)) begin
                           head_in      = '0;
                           rsp_value_in = '0;
                        end else begin
                           head_in = next_head;
                        end
                     end
                  end
                  OP_ROTATE: begin
                     if (count_ff == '0) begin
                        rsp_load   = 1'b1;
                        rsp_err_in = ERR_EMPTY;
                     end else if (req_chan.rotate_amount == '0) begin
                        rsp_load   = 1'b1;
                        rsp_err_in = ERR_ZERO;
                     end else begin
                        // fetch the front word, the walk starts next cycle
                        mem_re    = 1'b1;
                        mem_raddr = head_ff;
                        steps_in  = req_chan.rotate_amount;
                        state_in  = S_ROT;
                     end
                  end
                  OP_NOP: begin
                     rsp_load = 1'b1;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         S_ROT: begin
            // move the fetched front word behind the tail
            mem_we    = 1'b1;
            mem_waddr = wr_pos;
            mem_wdata = rd_data;
            tail_in   = rd_data;
            head_in   = next_head;
            steps_in  = steps_ff - AMT_W'(1);
            if (steps_ff != AMT_W'(1)) begin
               mem_re    = 1'b1;
               mem_raddr = next_head;
            end else begin
               state_in     = S_IDLE;
               rsp_load     = 1'b1;
               rsp_value_in = rd_data;
               rsp_size_in  = count_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_ff       <= mem_we && mem_re && (mem_waddr == mem_raddr);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      tail_ff     <= tail_in;
      fwd_data_ff <= mem_wdata;
      if (rsp_load) begin
         rsp_value_ff <= rsp_value_in;
         rsp_size_ff  <= rsp_size_in;
         rsp_err_ff   <= rsp_err_in;
      end
   end

   // ring store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         item_store_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rd_ff <= item_store_ff[mem_raddr];
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.current_value = rsp_value_ff;
   assign rsp_chan.queue_size    = rsp_size_ff;
   assign rsp_chan.is_empty      = (rsp_size_ff == '0);
   assign rsp_chan.error_code    = rsp_err_ff;

endmodule

// ===== hdl/rcq_checker.sv =====
// port-level checks of the rotating circular queue and their binding
module rcq_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [rcq_pkg::VALUE_WIDTH-1:0] rsp_current_value,
   input logic        [rcq_pkg::CNT_W-1:0]       rsp_queue_size,
   input logic                                   rsp_is_empty,
   input rcq_pkg::err_type                       rsp_error_code
);
   import rcq_pkg::*;

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_current_value)
         && $stable(rsp_queue_size) && $stable(rsp_error_code))
      else $error("stalled response word changed");

   // empty flag agrees with the size
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_queue_size == '0)))
      else $error("empty flag disagrees with size");

   // size never exceeds the ring
   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_queue_size <= CNT_W'(DEPTH)))
      else $error("size above depth");

   // an empty queue reports a zero value
   a_empty_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> (rsp_current_value == '0))
      else $error("empty queue with nonzero value");

   // full error only on a full ring, empty error only on an empty one
   a_err_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_error_code != ERR_FULL) || (rsp_queue_size == CNT_W'(DEPTH)))
         && ((rsp_error_code != ERR_EMPTY) || rsp_is_empty))
      else $error("error code inconsistent with size");

endmodule

bind rotating_circular_queue_unit rcq_checker u_rcq_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_current_value (rsp_chan.current_value),
   .rsp_queue_size    (rsp_chan.queue_size),
   .rsp_is_empty      (rsp_chan.is_empty),
   .rsp_error_code    (rsp_chan.error_code)
);
